[rtl/lseg_pkg.sv]
// LED strip effect generator package: effect modes, frame descriptor,
// configuration record, hue wheel and LFSR helpers. No dependencies.
package lseg_pkg;

  localparam int unsigned LED_IDX_W = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 12;
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
  localparam logic [31:0] LFSR_SEED = 32'd1;
  localparam logic [11:0] ADC_MAX   = 12'd4095;

  typedef enum logic [2:0] {
    MODE_FADE    = 3'd0,
    MODE_STROBE  = 3'd1,
    MODE_BAR     = 3'd2,
    MODE_RAINBOW = 3'd3,
    MODE_GLOW    = 3'd4,
    MODE_VOLUME  = 3'd5,
    MODE_OFF     = 3'd6
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BRIGHT  = 3'd0,
    CFG_ADC_THRESH  = 3'd1,
    CFG_HUE_PERIOD  = 3'd2,
    CFG_RBOW_PERIOD = 3'd3,
    CFG_STRB_PERIOD = 3'd4,
    CFG_BAR_PERIOD  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_LAUNCH0,
    FS_WAIT0,
    FS_PUSH
  } fstate_e;

  typedef struct packed {
    logic [7:0]  peak_level;
    logic [11:0] audio_floor;
    logic [7:0]  hue_period;
    logic [7:0]  rainbow_period;
    logic [7:0]  strobe_period;
    logic [7:0]  bar_period;
  } cfg_t;

  typedef struct packed {
    mode_e            mode;
    logic [7:0]       level;
    logic [7:0]       hue;
    logic [CNT_W-1:0] count;
    logic [23:0]      colour;
  } desc_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  function automatic rgb_t wheel(input logic [7:0] h);
    rgb_t c;
    logic [7:0] hh;
    logic [7:0] t;
    if (h < 8'd85) begin
      t   = 8'(h * 8'd3);
      c.r = t;
      c.g = 8'd255 - t;
      c.b = 8'd0;
    end else if (h < 8'd170) begin
      hh  = h - 8'd85;
      t   = 8'(hh * 8'd3);
      c.r = 8'd255 - t;
      c.g = 8'd0;
      c.b = t;
    end else begin
      hh  = h - 8'd170;
      t   = 8'(hh * 8'd3);
      c.r = 8'd0;
      c.g = t;
      c.b = 8'd255 - t;
    end
    return c;
  endfunction

  function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] l);
    logic [15:0] p;
    p = c * l;
    return p[15:8];
  endfunction

  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    logic [31:0] n;
    n = {1'b0, s[31:1]};
    return s[0] ? (n ^ LFSR_MASK) : n;
  endfunction

  function automatic logic [11:0] period(input logic [7:0] p);
    return (p == 8'd0) ? 12'd1 : {4'd0, p};
  endfunction

endpackage

[rtl/lseg_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing.
module lseg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [11:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [11:0] rem_o
);

  logic [31:0] quo_q, quo_d;
  logic [11:0] rem_q, rem_d, div_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;
  logic [12:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[31]};
    ge     = rem_sh >= {1'b0, div_q};
    rem_d  = ge ? 12'(rem_sh - {1'b0, div_q}) : rem_sh[11:0];
    quo_d  = {quo_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[rtl/lseg_front.sv]
// Frame front end: accepts frame ticks, updates effect state once per frame
// and issues frame descriptors. Depends on lseg_pkg and lseg_div.
module lseg_front
  import lseg_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 29,
  parameter int unsigned FADE_LEN = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_advance_i,
  input  logic [11:0] audio_sample_i,
  output logic        push_o,
  output desc_t       desc_o,
  input  logic        full_i
);

  localparam int unsigned      FADE_HALF  = FADE_LEN / 2;
  localparam logic [5:0]       FADE_N     = 6'(FADE_LEN);
  localparam logic [16:0]      FADE_RECIP = 17'((65536 + FADE_HALF - 1) / FADE_HALF);
  localparam logic [CNT_W-1:0] LEDS_N     = CNT_W'(NUM_LEDS);

  fstate_e          state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [31:0]      fc_q, fc_d;
  logic [5:0]       fmod_q, fmod_d;
  logic [11:0]      sample_q, sample_d;
  logic [7:0]       fhue_q, fhue_d, flevel_q, flevel_d;
  logic             ffall_q, ffall_d;
  logic [5:0]       fcnt_q, fcnt_d;
  logic             son_q, son_d;
  logic [23:0]      scol_q, scol_d;
  logic [31:0]      lfsr_q, lfsr_d;
  logic [CNT_W-1:0] blevel_q, blevel_d;
  logic             bfall_q, bfall_d;
  logic [7:0]       bhue_q, bhue_d, rbow_q, rbow_d, glow_q, glow_d;
  logic [14:0]      smooth_q, smooth_d;
  logic             hit0_q, hit0_d;
  logic [7:0]       quo0_q, quo0_d;

  logic        div_start, div_done;
  logic [31:0] div_dvd, div_quot;
  logic [11:0] div_dvs, div_rem;

  lseg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FS_IDLE;
      mode_q   <= MODE_FADE;
      fc_q     <= '0;
      fmod_q   <= '0;
      fhue_q   <= '0;
      flevel_q <= '0;
      ffall_q  <= 1'b0;
      fcnt_q   <= '0;
      son_q    <= 1'b0;
      scol_q   <= '0;
      lfsr_q   <= LFSR_SEED;
      blevel_q <= '0;
      bfall_q  <= 1'b0;
      bhue_q   <= '0;
      rbow_q   <= '0;
      glow_q   <= '0;
      smooth_q <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      fc_q     <= fc_d;
      fmod_q   <= fmod_d;
      fhue_q   <= fhue_d;
      flevel_q <= flevel_d;
      ffall_q  <= ffall_d;
      fcnt_q   <= fcnt_d;
      son_q    <= son_d;
      scol_q   <= scol_d;
      lfsr_q   <= lfsr_d;
      blevel_q <= blevel_d;
      bfall_q  <= bfall_d;
      bhue_q   <= bhue_d;
      rbow_q   <= rbow_d;
      glow_q   <= glow_d;
      smooth_q <= smooth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    hit0_q   <= hit0_d;
    quo0_q   <= quo0_d;
  end

  always_comb begin
    mode_e        nxt;
    logic [11:0]  diff;
    logic [11:0]  den;
    logic [19:0]  num;
    logic         above;
    logic [9:0]   lv;
    logic [5:0]   cinc;
    logic [18:0]  prod;
    logic [14:0]  target;
    logic [CNT_W:0] bl;
    logic [8:0]   hsum;
    logic [31:0]  l1, l2, l3;
    logic [7:0]   lvl;
    logic         post_hit;
    logic [23:0]  sprod;
    logic [7:0]   fstep;

    state_d  = state_q;
    mode_d   = mode_q;
    fc_d     = fc_q;
    fmod_d   = fmod_q;
    sample_d = sample_q;
    fhue_d   = fhue_q;
    flevel_d = flevel_q;
    ffall_d  = ffall_q;
    fcnt_d   = fcnt_q;
    son_d    = son_q;
    scol_d   = scol_q;
    lfsr_d   = lfsr_q;
    blevel_d = blevel_q;
    bfall_d  = bfall_q;
    bhue_d   = bhue_q;
    rbow_d   = rbow_q;
    glow_d   = glow_q;
    smooth_d = smooth_q;
    hit0_d   = hit0_q;
    quo0_d   = quo0_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = 12'd1;

    nxt   = (mode_q == MODE_OFF) ? MODE_FADE : mode_e'(mode_q + 3'd1);
    diff  = sample_q - cfg_i.audio_floor;
    den   = ADC_MAX - cfg_i.audio_floor;
    num   = diff * cfg_i.peak_level;
    above = sample_q >= cfg_i.audio_floor;
    sprod = cfg_i.peak_level * FADE_RECIP;
    fstep = sprod[23:16];

    lv = '0; cinc = '0; prod = '0; target = '0; bl = '0; hsum = '0;
    l1 = '0; l2 = '0; l3 = '0; lvl = '0; post_hit = 1'b0;

    unique case (state_q)
      FS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          sample_d = audio_sample_i;
          if (mode_advance_i) begin
            mode_d = nxt;
            fc_d   = '0;
            fmod_d = '0;
            unique case (nxt)
              MODE_FADE: begin
                fhue_d = '0; flevel_d = '0; ffall_d = 1'b0; fcnt_d = '0;
              end
              MODE_STROBE: begin
                son_d = 1'b0; scol_d = '0;
              end
              MODE_BAR: begin
                blevel_d = '0; bfall_d = 1'b0; bhue_d = '0;
              end
              MODE_RAINBOW: rbow_d = '0;
              default: ;
            endcase
          end
          state_d = FS_LAUNCH0;
        end
      end
      FS_LAUNCH0: begin
        div_start = 1'b1;
        unique case (mode_q)
          MODE_FADE: begin
            div_dvd = fc_q; div_dvs = period(cfg_i.hue_period);
          end
          MODE_STROBE: begin
            div_dvd = fc_q + 32'd1; div_dvs = period(cfg_i.strobe_period);
          end
          MODE_BAR, MODE_VOLUME: begin
            div_dvd = fc_q + 32'd1; div_dvs = period(cfg_i.bar_period);
          end
          MODE_RAINBOW: begin
            div_dvd = fc_q + 32'd1; div_dvs = period(cfg_i.rainbow_period);
          end
          MODE_GLOW: begin
            div_dvd = {12'd0, num}; div_dvs = den;
          end
          default: ;
        endcase
        state_d = FS_WAIT0;
      end
      FS_WAIT0: begin
        if (div_done) begin
          hit0_d  = div_rem == 12'd0;
          quo0_d  = (div_quot > {24'd0, cfg_i.peak_level}) ?
                    cfg_i.peak_level : div_quot[7:0];
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FS_IDLE;
          fc_d    = fc_q + 32'd1;
          fmod_d  = (fc_q == '1 || fmod_q == FADE_N - 6'd1) ? '0 : fmod_q + 6'd1;
          post_hit = hit0_q;
          unique case (mode_q)
            MODE_FADE: begin
              if (hit0_q) fhue_d = fhue_q + 8'd1;
              if (fmod_q == '0) begin
                lv = ffall_q ? ({2'b0, flevel_q} - {2'b0, fstep})
                             : ({2'b0, flevel_q} + {2'b0, fstep});
                cinc = fcnt_q + 6'd1;
                if (cinc >= FADE_N) begin
                  fcnt_d  = '0;
                  ffall_d = ~ffall_q;
                end else begin
                  fcnt_d = cinc;
                end
                if (lv[9]) flevel_d = '0;
                else if (lv[8:0] > {1'b0, cfg_i.peak_level})
                  flevel_d = cfg_i.peak_level;
                else flevel_d = lv[7:0];
              end
            end
            MODE_STROBE: begin
              if (post_hit) begin
                son_d = ~son_q;
                if (!son_q) begin
                  l1 = lfsr_step(lfsr_q);
                  l2 = lfsr_step(l1);
                  l3 = lfsr_step(l2);
                  lfsr_d = l3;
                  scol_d = {l2[7:0], l1[7:0], l3[7:0]};
                end
              end
            end
            MODE_BAR: begin
              if (post_hit) begin
                if (bfall_q) begin
                  if (blevel_q <= CNT_W'(2)) begin
                    blevel_d = '0; bfall_d = 1'b0;
                  end else blevel_d = blevel_q - CNT_W'(2);
                end else begin
                  bl = {1'b0, blevel_q} + (CNT_W+1)'(2);
                  if (bl >= {1'b0, LEDS_N}) begin
                    blevel_d = LEDS_N; bfall_d = 1'b1;
                  end else blevel_d = bl[CNT_W-1:0];
                end
                hsum   = {1'b0, bhue_q} + 9'd5;
                bhue_d = hsum[8] ? 8'd0 : hsum[7:0];
              end
            end
            MODE_RAINBOW: begin
              if (post_hit) begin
                hsum   = {1'b0, rbow_q} + 9'd5;
                rbow_d = hsum[8] ? 8'd0 : hsum[7:0];
              end
            end
            MODE_GLOW: begin
              if (!fc_q[0]) begin
                if (!above) glow_d = '0;
                else if (den == 12'd0) glow_d = cfg_i.peak_level;
                else glow_d = quo0_q;
              end
            end
            MODE_VOLUME: begin
              prod   = sample_q * LEDS_N;
              target = above ? prod[18:4] : 15'd0;
              if (smooth_q < target)
                smooth_d = smooth_q + ((target - smooth_q) >> 3);
              else
                smooth_d = smooth_q - ((smooth_q - target) >> 3);
              if (post_hit) begin
                hsum   = {1'b0, bhue_q} + 9'd5;
                bhue_d = hsum[8] ? 8'd0 : hsum[7:0];
              end
            end
            default: ;
          endcase
        end
      end
    endcase

    unique case (mode_q)
      MODE_FADE:    lvl = flevel_d;
      MODE_RAINBOW: lvl = cfg_i.peak_level;
      default:      lvl = glow_d;
    endcase
    desc_o.mode   = mode_q;
    desc_o.level  = lvl;
    desc_o.hue    = (mode_q == MODE_FADE) ? fhue_d :
                    (mode_q == MODE_RAINBOW) ? rbow_q : bhue_q;
    desc_o.count  = (mode_q == MODE_VOLUME) ? smooth_d[14:8] : blevel_q;
    desc_o.colour = son_q ? scol_q : 24'd0;
  end

endmodule

[rtl/lseg_fifo.sv]
// Two-entry descriptor queue between front end and pixel engine.
// Depends on lseg_pkg.
module lseg_fifo
  import lseg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output desc_t data_o
);

  desc_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

endmodule

[rtl/lseg_back.sv]
// Pixel engine: walks the LEDs of one frame descriptor into an output register,
// one per cycle unless the receiver stalls. Depends on lseg_pkg.
module lseg_back
  import lseg_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 29
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  desc_t                desc_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LED_IDX_W-1:0] led_index_o,
  output logic [7:0]           green_o,
  output logic [7:0]           red_o,
  output logic [7:0]           blue_o,
  output logic                 last_led_o
);

  localparam logic [7:0]           RB_Q  = 8'(255 / NUM_LEDS);
  localparam logic [CNT_W-1:0]     RB_R  = CNT_W'(255 % NUM_LEDS);
  localparam logic [CNT_W-1:0]     LED_N = CNT_W'(NUM_LEDS);
  localparam logic [LED_IDX_W-1:0] LAST  = LED_IDX_W'(NUM_LEDS - 1);

  logic [LED_IDX_W-1:0] idx_q;
  logic [7:0]           accq_q;
  logic [CNT_W-1:0]     accr_q;
  logic                 ov_q;
  logic                 load;
  logic [CNT_W-1:0]     rsum;
  rgb_t                 pix, wh;
  logic [7:0]           hue, glow;
  logic [LED_IDX_W-1:0] idx_oq;
  rgb_t                 pix_q;
  logic                 last_q;

  assign load  = !empty_i && (!ov_q || out_ready_i);
  assign pop_o = load && (idx_q == LAST);
  assign rsum  = accr_q + RB_R;

  always_comb begin
    pix  = '0;
    hue  = '0;
    unique case (desc_i.mode)
      MODE_FADE: hue = desc_i.hue;
      MODE_RAINBOW: hue = desc_i.hue + accq_q;
      default: hue = desc_i.hue + {idx_q[4:0], 3'd0};
    endcase
    wh   = wheel(hue);
    glow = scale8(8'd255, desc_i.level);
    unique case (desc_i.mode)
      MODE_FADE, MODE_RAINBOW: begin
        pix.r = scale8(wh.r, desc_i.level);
        pix.g = scale8(wh.g, desc_i.level);
        pix.b = scale8(wh.b, desc_i.level);
      end
      MODE_STROBE: begin
        pix.g = desc_i.colour[23:16];
        pix.r = desc_i.colour[15:8];
        pix.b = desc_i.colour[7:0];
      end
      MODE_BAR, MODE_VOLUME: begin
        if ({1'b0, idx_q} < desc_i.count) pix = wh;
      end
      MODE_GLOW: begin
        pix.r = glow;
        pix.b = glow;
      end
      default: pix = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      idx_q  <= '0;
      accq_q <= '0;
      accr_q <= '0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
        if (pop_o) begin
          idx_q  <= '0;
          accq_q <= '0;
          accr_q <= '0;
        end else begin
          idx_q <= idx_q + LED_IDX_W'(1);
          if (rsum >= LED_N) begin
            accq_q <= accq_q + RB_Q + 8'd1;
            accr_q <= rsum - LED_N;
          end else begin
            accq_q <= accq_q + RB_Q;
            accr_q <= rsum;
          end
        end
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      idx_oq <= idx_q;
      pix_q  <= pix;
      last_q <= idx_q == LAST;
    end
  end

  assign out_valid_o = ov_q;
  assign led_index_o = idx_oq;
  assign green_o     = pix_q.g;
  assign red_o       = pix_q.r;
  assign blue_o      = pix_q.b;
  assign last_led_o  = last_q;

endmodule

[rtl/led_strip_effect_generator.sv]
// LED strip effect generator top level: configuration registers, front end,
// descriptor queue and pixel engine. Depends on lseg_pkg and all lseg modules.
//
// Usage: each accepted input transfer is one frame tick (mode_advance_i,
// audio_sample_i). It yields NUM_LEDS output transfers, one per LED in order,
// led_index_o counting from 0 and last_led_o set on the final LED.
// Registers are written through cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o
// is always high. Write only while no frame is in flight.
// Frame path: the front end runs the shared divider once per frame, pushes
// the descriptor into the queue, and the pixel engine registers each LED.
// Overlap: the front end handles one frame tick at a time and the pixel
// engine emits one LED per cycle while the receiver is ready; a two-deep frame
// queue lets the front end process the next tick while LEDs stream out.
// Reset: all effect state and configuration registers return to defaults, mode fading hue.
// A stalled receiver holds the output register; the queue then fills and
// in_ready_o drops until space returns.
module led_strip_effect_generator
  import lseg_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 29,
  parameter int unsigned FADE_LEN = 50
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_advance_i,
  input  logic [11:0]          audio_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LED_IDX_W-1:0] led_index_o,
  output logic [7:0]           green_o,
  output logic [7:0]           red_o,
  output logic [7:0]           blue_o,
  output logic                 last_led_o
);

  cfg_t  cfg_q;
  logic  push, full, pop, empty;
  desc_t desc_w, desc_r;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_level     <= 8'd40;
      cfg_q.audio_floor    <= 12'd1900;
      cfg_q.hue_period     <= 8'd5;
      cfg_q.rainbow_period <= 8'd3;
      cfg_q.strobe_period  <= 8'd40;
      cfg_q.bar_period     <= 8'd20;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_BRIGHT:  cfg_q.peak_level     <= cfg_data_i[7:0];
        CFG_ADC_THRESH:  cfg_q.audio_floor    <= cfg_data_i;
        CFG_HUE_PERIOD:  cfg_q.hue_period     <= cfg_data_i[7:0];
        CFG_RBOW_PERIOD: cfg_q.rainbow_period <= cfg_data_i[7:0];
        CFG_STRB_PERIOD: cfg_q.strobe_period  <= cfg_data_i[7:0];
        CFG_BAR_PERIOD:  cfg_q.bar_period     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  lseg_front #(
    .NUM_LEDS (NUM_LEDS),
    .FADE_LEN (FADE_LEN)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_advance_i (mode_advance_i),
    .audio_sample_i (audio_sample_i),
    .push_o         (push),
    .desc_o         (desc_w),
    .full_i         (full)
  );

  lseg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (desc_w),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (desc_r)
  );

  lseg_back #(
    .NUM_LEDS (NUM_LEDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .desc_i      (desc_r),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .led_index_o (led_index_o),
    .green_o     (green_o),
    .red_o       (red_o),
    .blue_o      (blue_o),
    .last_led_o  (last_led_o)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("descriptor pushed into full queue");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_led_o |-> led_index_o == LED_IDX_W'(NUM_LEDS - 1))
    else $error("last LED flag on wrong index");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("front end ready right after accepting a frame");
`endif

endmodule
